@@ design/source_code_tokenizer_unit_macros.svh @@
// Assertion macros for the tokenizer checker.
`ifndef SOURCE_CODE_TOKENIZER_UNIT_MACROS_SVH
`define SOURCE_CODE_TOKENIZER_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/sct_pkg.sv @@
//------------------------------------------------------------------------------
// sct_pkg
// Shared types and constants of the source code tokenizer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package sct_pkg;
    localparam int MaxTokenLength = 255;
    localparam logic [7:0] LEN_CAP = (MaxTokenLength < 255) ? 8'(MaxTokenLength) : 8'd255;
    localparam logic [62:0] VALUE_MAX = {63{1'b1}};

    typedef enum logic [3:0] {
        K_END = 4'd0, K_IDENT = 4'd1, K_IF = 4'd2, K_FOR = 4'd3, K_ELSE = 4'd4,
        K_TRUE = 4'd5, K_WHILE = 4'd6, K_FALSE = 4'd7, K_RETURN = 4'd8,
        K_INT = 4'd9, K_FLOAT = 4'd10, K_STRING = 4'd11, K_SYMBOL = 4'd12,
        K_PAIR = 4'd13, K_ERROR = 4'd14
    } kind_t;

    typedef enum logic [9:0] {
        M_IDLE = 10'b0000000001, M_WORD = 10'b0000000010, M_INT = 10'b0000000100,
        M_DOT = 10'b0000001000, M_FRAC = 10'b0000010000, M_STRING = 10'b0000100000,
        M_PEND = 10'b0001000000, M_LINE = 10'b0010000000, M_BLOCK = 10'b0100000000,
        M_BSTAR = 10'b1000000000
    } mode_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  first_symbol;
        logic [7:0]  second_symbol;
        logic [7:0]  token_length;
        logic [62:0] token_value;
        logic [15:0] line_number;
    } token_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] len_inc(input logic [7:0] n);
        return (n < LEN_CAP) ? n + 8'd1 : LEN_CAP;
    endfunction
endpackage

@@ design/sct_step.sv @@
//------------------------------------------------------------------------------
// sct_step
// Scanner state and per-byte next-state / token logic.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module sct_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic [7:0]      character,
    output logic [1:0]      count,
    output sct_pkg::token_t tok0,
    output sct_pkg::token_t tok1
);
    import sct_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [47:0] prefix_reg, prefix_next;
    logic [7:0]  len_reg, len_next;
    logic [62:0] acc_reg, acc_next;
    logic [7:0]  pend_reg, pend_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] sline_reg, sline_next;

    logic [7:0]  c;
    logic        letter, digit, word, opch, pairs, run_idle;
    logic [3:0]  d;
    logic [66:0] acc_mul;
    logic        sat;
    logic [3:0]  wkind;
    token_t      pre_tok, idle_tok;
    logic        pre_v, idle_v;

    assign c      = character;
    assign letter = is_letter(c);
    assign digit  = is_digit(c);
    assign word   = letter | digit;
    assign d      = 4'(c - "0");
    assign opch   = c == "=" || c == "+" || c == "-" || c == "*" || c == "/" || c == "!"
                 || c == "<" || c == ">" || c == ":" || c == "." || c == "&" || c == "|";
    // acc * 10 as (acc << 3) + (acc << 1)
    assign acc_mul = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0} + 67'(d);
    assign sat     = acc_mul > {4'b0, VALUE_MAX};

    always_comb
    begin
        pairs = 1'b0;
        if (c == "=" && (pend_reg == "=" || pend_reg == "+" || pend_reg == "-"
            || pend_reg == "*" || pend_reg == "/" || pend_reg == "!"
            || pend_reg == "<" || pend_reg == ">"))
            pairs = 1'b1;
        if (c == pend_reg && (pend_reg == "+" || pend_reg == "-" || pend_reg == ":"
            || pend_reg == "." || pend_reg == "&" || pend_reg == "|"))
            pairs = 1'b1;
        if (pend_reg == "-" && c == ">")
            pairs = 1'b1;
    end

    always_comb
    begin
        wkind = K_IDENT;
        case (len_reg)
            8'd2: if (prefix_reg[15:0] == "if") wkind = K_IF;
            8'd3: if (prefix_reg[23:0] == "for") wkind = K_FOR;
            8'd4:
            begin
                if (prefix_reg[31:0] == "else") wkind = K_ELSE;
                if (prefix_reg[31:0] == "true") wkind = K_TRUE;
            end
            8'd5:
            begin
                if (prefix_reg[39:0] == "while") wkind = K_WHILE;
                if (prefix_reg[39:0] == "false") wkind = K_FALSE;
            end
            8'd6: if (prefix_reg == "return") wkind = K_RETURN;
            default: wkind = K_IDENT;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        prefix_next = prefix_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        line_next  = line_reg;
        sline_next = sline_reg;
        pre_v      = 1'b0;
        pre_tok    = '0;
        run_idle   = 1'b0;
        idle_v     = 1'b0;
        idle_tok   = '0;

        case (mode_reg)
            M_WORD:
                if (word)
                begin
                    if (len_reg < 8'd6) prefix_next = {prefix_reg[39:0], c};
                    len_next = len_inc(len_reg);
                end
                else
                begin
                    pre_v = 1'b1;
                    pre_tok.kind = wkind;
                    pre_tok.token_length = len_reg;
                    pre_tok.line_number = sline_reg;
                    run_idle = 1'b1;
                end
            M_INT:
                if (digit)
                begin
                    acc_next = sat ? VALUE_MAX : acc_mul[62:0];
                    len_next = len_inc(len_reg);
                end
                else if (c == ".")
                    mode_next = M_DOT;
                else
                begin
                    pre_v = 1'b1;
                    pre_tok.kind = K_INT;
                    pre_tok.token_length = len_reg;
                    pre_tok.token_value = acc_reg;
                    pre_tok.line_number = sline_reg;
                    run_idle = 1'b1;
                end
            M_DOT:
                if (digit)
                begin
                    mode_next = M_FRAC;
                    len_next = len_inc(len_inc(len_reg));
                end
                else if (c == ".")
                begin
                    pre_v = 1'b1;
                    pre_tok.kind = K_INT;
                    pre_tok.token_length = len_reg;
                    pre_tok.token_value = acc_reg;
                    pre_tok.line_number = sline_reg;
                    idle_v = 1'b1;
                    idle_tok.kind = K_PAIR;
                    idle_tok.first_symbol = ".";
                    idle_tok.second_symbol = ".";
                    idle_tok.line_number = line_reg;
                    mode_next = M_IDLE;
                end
                else
                begin
                    pre_v = 1'b1;
                    pre_tok.kind = K_FLOAT;
                    pre_tok.token_length = len_inc(len_reg);
                    pre_tok.line_number = sline_reg;
                    run_idle = 1'b1;
                end
            M_FRAC:
                if (digit)
                    len_next = len_inc(len_reg);
                else
                begin
                    pre_v = 1'b1;
                    pre_tok.kind = K_FLOAT;
                    pre_tok.token_length = len_reg;
                    pre_tok.line_number = sline_reg;
                    run_idle = 1'b1;
                end
            M_STRING:
                if (word)
                    len_next = len_inc(len_reg);
                else if (c == "\"")
                begin
                    pre_v = 1'b1;
                    pre_tok.kind = K_STRING;
                    pre_tok.token_length = len_reg;
                    pre_tok.line_number = sline_reg;
                    mode_next = M_IDLE;
                end
                else
                begin
                    pre_v = 1'b1;
                    pre_tok.kind = K_ERROR;
                    pre_tok.token_length = len_reg;
                    pre_tok.line_number = sline_reg;
                    run_idle = 1'b1;
                end
            M_PEND:
                if (pend_reg == "/" && c == "/")
                    mode_next = M_LINE;
                else if (pend_reg == "/" && c == "*")
                    mode_next = M_BLOCK;
                else if (pairs)
                begin
                    pre_v = 1'b1;
                    pre_tok.kind = K_PAIR;
                    pre_tok.first_symbol = pend_reg;
                    pre_tok.second_symbol = c;
                    pre_tok.line_number = sline_reg;
                    mode_next = M_IDLE;
                end
                else
                begin
                    pre_v = 1'b1;
                    pre_tok.kind = K_SYMBOL;
                    pre_tok.first_symbol = pend_reg;
                    pre_tok.line_number = sline_reg;
                    run_idle = 1'b1;
                end
            M_LINE:
                if (c == "\n")
                begin
                    line_next = line_reg + 16'd1;
                    mode_next = M_IDLE;
                end
                else if (c == 8'd0)
                    run_idle = 1'b1;
            M_BLOCK, M_BSTAR:
                if (c == 8'd0)
                    run_idle = 1'b1;
                else if (c == "/" && mode_reg == M_BSTAR)
                    mode_next = M_IDLE;
                else
                begin
                    if (c == "\n") line_next = line_reg + 16'd1;
                    mode_next = (c == "*") ? M_BSTAR : M_BLOCK;
                end
            default:
                run_idle = 1'b1;
        endcase

        if (run_idle)
        begin
            mode_next = M_IDLE;
            if (c == 8'd0)
            begin
                idle_v = 1'b1;
                idle_tok.kind = K_END;
                idle_tok.line_number = line_reg;
            end
            else if (c == " ")
            begin
            end
            else if (c == "\n")
                line_next = line_reg + 16'd1;
            else if (letter)
            begin
                mode_next = M_WORD;
                prefix_next = {40'd0, c};
                len_next = 8'd1;
                sline_next = line_reg;
            end
            else if (digit)
            begin
                mode_next = M_INT;
                acc_next = 63'(d);
                len_next = 8'd1;
                sline_next = line_reg;
            end
            else if (c == "\"")
            begin
                mode_next = M_STRING;
                len_next = 8'd0;
                sline_next = line_reg;
            end
            else if (opch)
            begin
                mode_next = M_PEND;
                pend_next = c;
                sline_next = line_reg;
            end
            else
            begin
                idle_v = 1'b1;
                idle_tok.kind = K_SYMBOL;
                idle_tok.first_symbol = c;
                idle_tok.line_number = line_reg;
            end
        end

        count = 2'(pre_v) + 2'(idle_v);
        tok0  = pre_v ? pre_tok : idle_tok;
        tok1  = idle_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            prefix_reg <= '0;
            len_reg    <= '0;
            acc_reg    <= '0;
            pend_reg   <= '0;
            line_reg   <= '0;
            sline_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            len_reg    <= len_next;
            acc_reg    <= acc_next;
            pend_reg   <= pend_next;
            line_reg   <= line_next;
            sline_reg  <= sline_next;
        end
    end
endmodule

@@ design/sct_outq.sv @@
//------------------------------------------------------------------------------
// sct_outq
// Four-entry result queue with valid/stall output.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module sct_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      count,
    input  sct_pkg::token_t tok0,
    input  sct_pkg::token_t tok1,
    output logic            room,
    output logic            out_valid,
    input  logic            out_stall,
    output sct_pkg::token_t head,
    output logic            head_last
);
    import sct_pkg::*;

    token_t     q_reg [4];
    logic       l_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] fill_reg, fill_next;
    logic       pop, push;

    assign out_valid = fill_reg != 3'd0;
    assign pop       = out_valid && !out_stall;
    assign room      = fill_reg <= 3'd2;
    assign push      = room;
    assign head      = q_reg[rd_reg];
    assign head_last = l_reg[rd_reg];
    assign fill_next = fill_reg + (push ? 3'(count) : 3'd0) - 3'(pop);

    always_ff @(posedge clk)
    begin
        if (push && count != 2'd0)
        begin
            q_reg[wr_reg] <= tok0;
            l_reg[wr_reg] <= count == 2'd1;
        end
        if (push && count == 2'd2)
        begin
            q_reg[wr_reg + 2'd1] <= tok1;
            l_reg[wr_reg + 2'd1] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (pop) rd_reg <= rd_reg + 2'd1;
            if (push) wr_reg <= wr_reg + count;
            fill_reg <= fill_next;
        end
    end
endmodule

@@ design/source_code_tokenizer_unit.sv @@
//------------------------------------------------------------------------------
// source_code_tokenizer_unit
// Byte-at-a-time source tokenizer.
//------------------------------------------------------------------------------
// Input channel: in_valid/in_stall with one source byte (character); byte 0
// ends the input and yields an end token.
// Output channel: out_valid/out_stall with one token per request; last marks
// the final token caused by one input byte (each byte gives 0, 1 or 2).
// Throughput: one byte per cycle while in_stall is low. A token is written
// into a four-entry queue when the byte that completes it is taken.
// in_stall rises when the queue holds three or more tokens, so a stalled
// receiver backs up the input once three or four tokens are queued.
// Reset clears the scanner to idle, the line counter to zero and empties
// the queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module source_code_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  kind,
    output logic [7:0]  first_symbol,
    output logic [7:0]  second_symbol,
    output logic [7:0]  token_length,
    output logic [62:0] token_value,
    output logic [15:0] line_number,
    output logic        last
);
    import sct_pkg::*;

    logic       room, advance;
    logic [1:0] count, qcount;
    token_t     tok0, tok1, head;

    assign in_stall = !room;
    assign advance  = in_valid && room;
    assign qcount   = advance ? count : 2'd0;

    sct_step u_step (
        .clk(clk), .rst_n(rst_n), .advance(advance), .character(character),
        .count(count), .tok0(tok0), .tok1(tok1)
    );

    sct_outq u_outq (
        .clk(clk), .rst_n(rst_n), .count(qcount), .tok0(tok0), .tok1(tok1),
        .room(room), .out_valid(out_valid), .out_stall(out_stall),
        .head(head), .head_last(last)
    );

    assign kind          = head.kind;
    assign first_symbol  = head.first_symbol;
    assign second_symbol = head.second_symbol;
    assign token_length  = head.token_length;
    assign token_value   = head.token_value;
    assign line_number   = head.line_number;
endmodule

@@ design/sct_checker.sv @@
//------------------------------------------------------------------------------
// sct_checker
// Port-level checks of the tokenizer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "source_code_tokenizer_unit_macros.svh"
module sct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  kind,
    input logic [7:0]  second_symbol,
    input logic [62:0] token_value
);
    import sct_pkg::*;

    `SCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(kind), "held")
    `SCT_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, kind <= K_ERROR, "bad token kind")
    `SCT_ASSERT_IMPL(a_val_int, clk, rst_n, out_valid && kind != K_INT, token_value == '0, "value")
    `SCT_ASSERT_IMPL(a_pair2, clk, rst_n, out_valid && kind != K_PAIR, second_symbol == '0, "pair")
    `SCT_ASSERT_NEXT(a_drain, clk, rst_n, !out_valid, !in_stall, "stall with empty queue")
endmodule

bind source_code_tokenizer_unit sct_checker u_sct_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .second_symbol(second_symbol), .token_value(token_value)
);
